// ===== sv/pdko_pkg.sv =====
// Package for the PD drive with delayed Kalman observer.
// Holds the state, micro-op and command types and the fixed micro-program.
// Used by every module of the block.
`default_nettype none
package pdko_pkg;

    localparam int DELAY_DEF = 20;
    localparam int NUM_STATE = 12;
    localparam logic signed [63:0] COV_INIT   = 64'sd2814749767107;
    localparam logic        [63:0] NOISE_BIAS = 64'd2814750;

    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CLAMP, OP_BR_FULL, OP_BR_POS, OP_END
    } op_t;

    typedef enum logic [2:0] {SH_0, SH_16, SH_30, SH_32, SH_48} sh_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FETCH, ST_EXEC, ST_WAIT, ST_WRITE, ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        CFG_PROP_GAIN, CFG_DERIV_GAIN, CFG_STEP_TIME, CFG_VELOCITY_DECAY,
        CFG_DRIVE_GAIN, CFG_NOISE_POSITION, CFG_NOISE_VELOCITY, CFG_NOISE_MEASURE
    } cfg_idx_t;

    // register file addresses
    localparam logic [6:0] R_X0 = 7'd0;
    localparam logic [6:0] R_X1 = 7'd1;
    localparam logic [6:0] R_X2 = 7'd2;
    localparam logic [6:0] R_P0 = 7'd3;
    localparam logic [6:0] R_P1 = 7'd4;
    localparam logic [6:0] R_P2 = 7'd5;
    localparam logic [6:0] R_P3 = 7'd6;
    localparam logic [6:0] R_P4 = 7'd7;
    localparam logic [6:0] R_P5 = 7'd8;
    localparam logic [6:0] R_P6 = 7'd9;
    localparam logic [6:0] R_P7 = 7'd10;
    localparam logic [6:0] R_P8 = 7'd11;

    // special operand sources
    localparam logic [6:0] S_ZERO  = 7'd64;
    localparam logic [6:0] S_ONE   = 7'd65;
    localparam logic [6:0] S_TWO32 = 7'd66;
    localparam logic [6:0] S_REF   = 7'd67;
    localparam logic [6:0] S_DLY   = 7'd68;
    localparam logic [6:0] S_KP    = 7'd69;
    localparam logic [6:0] S_KD    = 7'd70;
    localparam logic [6:0] S_DT    = 7'd71;
    localparam logic [6:0] S_DECAY = 7'd72;
    localparam logic [6:0] S_DG    = 7'd73;
    localparam logic [6:0] S_QP    = 7'd74;
    localparam logic [6:0] S_QV    = 7'd75;
    localparam logic [6:0] S_QB    = 7'd76;
    localparam logic [6:0] S_R     = 7'd77;

    localparam logic [6:0] PC_END = 7'd78;

    typedef struct packed {
        op_t        op;
        logic [6:0] dst;
        logic [6:0] a;
        logic [6:0] b;
        sh_t        sh;
    } uop_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic write;
        logic set_corr;
        logic load_out;
        uop_t uop;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic nonpos;
        logic done;
    } stat_t;

    function automatic logic [6:0] tmp(input int n);
        return 7'(12 + n);
    endfunction

    function automatic uop_t mk(input op_t op, input logic [6:0] dst,
                                input logic [6:0] a, input logic [6:0] b, input sh_t sh);
        uop_t u;
        u.op  = op;
        u.dst = dst;
        u.a   = a;
        u.b   = b;
        u.sh  = sh;
        return u;
    endfunction

    function automatic uop_t ucode(input logic [6:0] pc);
        uop_t u;
        unique case (pc)
            // PD drive
            7'd0:  u = mk(OP_MUL,   tmp(0),  R_X0,    S_ONE,   SH_32);
            7'd1:  u = mk(OP_SUB,   tmp(1),  S_REF,   tmp(0),  SH_0);
            7'd2:  u = mk(OP_MUL,   tmp(2),  tmp(1),  S_KP,    SH_16);
            7'd3:  u = mk(OP_MUL,   tmp(3),  R_X1,    S_ONE,   SH_32);
            7'd4:  u = mk(OP_SUB,   tmp(4),  S_ZERO,  tmp(3),  SH_0);
            7'd5:  u = mk(OP_MUL,   tmp(5),  tmp(4),  S_KD,    SH_16);
            7'd6:  u = mk(OP_ADD,   tmp(6),  tmp(2),  tmp(5),  SH_0);
            7'd7:  u = mk(OP_CLAMP, tmp(7),  tmp(6),  S_ZERO,  SH_0);
            // state prediction
            7'd8:  u = mk(OP_MUL,   tmp(8),  R_X1,    S_DT,    SH_32);
            7'd9:  u = mk(OP_ADD,   R_X0,    R_X0,    tmp(8),  SH_0);
            7'd10: u = mk(OP_MUL,   tmp(9),  R_X1,    S_DECAY, SH_30);
            7'd11: u = mk(OP_MUL,   tmp(10), tmp(7),  S_DG,    SH_0);
            7'd12: u = mk(OP_ADD,   R_X1,    tmp(9),  tmp(10), SH_0);
            // M = Ad P
            7'd13: u = mk(OP_MUL,   tmp(17), R_P3,    S_DT,    SH_32);
            7'd14: u = mk(OP_ADD,   tmp(11), R_P0,    tmp(17), SH_0);
            7'd15: u = mk(OP_MUL,   tmp(17), R_P4,    S_DT,    SH_32);
            7'd16: u = mk(OP_ADD,   tmp(12), R_P1,    tmp(17), SH_0);
            7'd17: u = mk(OP_MUL,   tmp(17), R_P5,    S_DT,    SH_32);
            7'd18: u = mk(OP_ADD,   tmp(13), R_P2,    tmp(17), SH_0);
            7'd19: u = mk(OP_MUL,   tmp(14), R_P3,    S_DECAY, SH_30);
            7'd20: u = mk(OP_MUL,   tmp(15), R_P4,    S_DECAY, SH_30);
            7'd21: u = mk(OP_MUL,   tmp(16), R_P5,    S_DECAY, SH_30);
            // P = M Ad^T
            7'd22: u = mk(OP_MUL,   tmp(17), tmp(12), S_DT,    SH_32);
            7'd23: u = mk(OP_ADD,   R_P0,    tmp(11), tmp(17), SH_0);
            7'd24: u = mk(OP_MUL,   R_P1,    tmp(12), S_DECAY, SH_30);
            7'd25: u = mk(OP_ADD,   R_P2,    tmp(13), S_ZERO,  SH_0);
            7'd26: u = mk(OP_MUL,   tmp(17), tmp(15), S_DT,    SH_32);
            7'd27: u = mk(OP_ADD,   R_P3,    tmp(14), tmp(17), SH_0);
            7'd28: u = mk(OP_MUL,   R_P4,    tmp(15), S_DECAY, SH_30);
            7'd29: u = mk(OP_ADD,   R_P5,    tmp(16), S_ZERO,  SH_0);
            7'd30: u = mk(OP_MUL,   tmp(17), R_P7,    S_DT,    SH_32);
            7'd31: u = mk(OP_ADD,   R_P6,    R_P6,    tmp(17), SH_0);
            7'd32: u = mk(OP_MUL,   R_P7,    R_P7,    S_DECAY, SH_30);
            7'd33: u = mk(OP_ADD,   R_P0,    R_P0,    S_QP,    SH_0);
            7'd34: u = mk(OP_ADD,   R_P4,    R_P4,    S_QV,    SH_0);
            7'd35: u = mk(OP_ADD,   R_P8,    R_P8,    S_QB,    SH_0);
            // delayed update
            7'd36: u = mk(OP_BR_FULL, S_ZERO, S_ZERO, S_ZERO,  SH_0);
            7'd37: u = mk(OP_ADD,   tmp(18), R_P0,    R_P2,    SH_0);
            7'd38: u = mk(OP_ADD,   tmp(19), R_P6,    R_P8,    SH_0);
            7'd39: u = mk(OP_ADD,   tmp(18), tmp(18), tmp(19), SH_0);
            7'd40: u = mk(OP_ADD,   tmp(20), tmp(18), S_R,     SH_0);
            7'd41: u = mk(OP_BR_POS, S_ZERO, S_ZERO,  S_ZERO,  SH_0);
            7'd42: u = mk(OP_MUL,   tmp(21), S_DLY,   S_TWO32, SH_0);
            7'd43: u = mk(OP_ADD,   tmp(22), R_X0,    R_X2,    SH_0);
            7'd44: u = mk(OP_SUB,   tmp(21), tmp(21), tmp(22), SH_0);
            7'd45: u = mk(OP_ADD,   tmp(23), R_P0,    R_P2,    SH_0);
            7'd46: u = mk(OP_DIV,   tmp(24), tmp(23), tmp(20), SH_0);
            7'd47: u = mk(OP_ADD,   tmp(23), R_P3,    R_P5,    SH_0);
            7'd48: u = mk(OP_DIV,   tmp(25), tmp(23), tmp(20), SH_0);
            7'd49: u = mk(OP_ADD,   tmp(23), R_P6,    R_P8,    SH_0);
            7'd50: u = mk(OP_DIV,   tmp(26), tmp(23), tmp(20), SH_0);
            7'd51: u = mk(OP_MUL,   tmp(27), tmp(24), tmp(21), SH_48);
            7'd52: u = mk(OP_ADD,   R_X0,    R_X0,    tmp(27), SH_0);
            7'd53: u = mk(OP_MUL,   tmp(27), tmp(25), tmp(21), SH_48);
            7'd54: u = mk(OP_ADD,   R_X1,    R_X1,    tmp(27), SH_0);
            7'd55: u = mk(OP_MUL,   tmp(27), tmp(26), tmp(21), SH_48);
            7'd56: u = mk(OP_ADD,   R_X2,    R_X2,    tmp(27), SH_0);
            7'd57: u = mk(OP_ADD,   tmp(28), R_P0,    R_P6,    SH_0);
            7'd58: u = mk(OP_ADD,   tmp(29), R_P1,    R_P7,    SH_0);
            7'd59: u = mk(OP_ADD,   tmp(30), R_P2,    R_P8,    SH_0);
            7'd60: u = mk(OP_MUL,   tmp(27), tmp(24), tmp(28), SH_48);
            7'd61: u = mk(OP_SUB,   R_P0,    R_P0,    tmp(27), SH_0);
            7'd62: u = mk(OP_MUL,   tmp(27), tmp(24), tmp(29), SH_48);
            7'd63: u = mk(OP_SUB,   R_P1,    R_P1,    tmp(27), SH_0);
            7'd64: u = mk(OP_MUL,   tmp(27), tmp(24), tmp(30), SH_48);
            7'd65: u = mk(OP_SUB,   R_P2,    R_P2,    tmp(27), SH_0);
            7'd66: u = mk(OP_MUL,   tmp(27), tmp(25), tmp(28), SH_48);
            7'd67: u = mk(OP_SUB,   R_P3,    R_P3,    tmp(27), SH_0);
            7'd68: u = mk(OP_MUL,   tmp(27), tmp(25), tmp(29), SH_48);
            7'd69: u = mk(OP_SUB,   R_P4,    R_P4,    tmp(27), SH_0);
            7'd70: u = mk(OP_MUL,   tmp(27), tmp(25), tmp(30), SH_48);
            7'd71: u = mk(OP_SUB,   R_P5,    R_P5,    tmp(27), SH_0);
            7'd72: u = mk(OP_MUL,   tmp(27), tmp(26), tmp(28), SH_48);
            7'd73: u = mk(OP_SUB,   R_P6,    R_P6,    tmp(27), SH_0);
            7'd74: u = mk(OP_MUL,   tmp(27), tmp(26), tmp(29), SH_48);
            7'd75: u = mk(OP_SUB,   R_P7,    R_P7,    tmp(27), SH_0);
            7'd76: u = mk(OP_MUL,   tmp(27), tmp(26), tmp(30), SH_48);
            7'd77: u = mk(OP_SUB,   R_P8,    R_P8,    tmp(27), SH_0);
            default: u = mk(OP_END, S_ZERO,  S_ZERO,  S_ZERO,  SH_0);
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

// ===== sv/pdko_mul.sv =====
// Shared 64x64 signed multiplier: four 32x32 partial products, floor shift, saturation.
// Depends on pdko_pkg for the shift codes.
`default_nettype none
module pdko_mul (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  wire  signed [63:0]  a,
    input  wire  signed [63:0]  b,
    input  pdko_pkg::sh_t       sh,
    output logic                done,
    output logic signed [63:0]  result
);
    import pdko_pkg::*;

    logic         busy_reg;
    logic [2:0]   phase_reg;
    logic [63:0]  ua_reg;
    logic [63:0]  ub_reg;
    logic         neg_reg;
    sh_t          sh_reg;
    logic [127:0] acc_reg;
    logic         done_reg;
    logic signed [63:0] result_reg;

    logic [31:0]  half_a;
    logic [31:0]  half_b;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [6:0]   pp_amt;
    logic [5:0]   shamt;
    logic signed [127:0] shifted;
    logic signed [63:0]  sat_val;

    always_comb
    begin
        half_a  = phase_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
        half_b  = phase_reg[0] ? ub_reg[63:32] : ub_reg[31:0];
        pp      = 64'(half_a) * 64'(half_b);
        pp_amt  = {phase_reg[1] & phase_reg[0], phase_reg[1] ^ phase_reg[0], 5'd0};
        pp_sh   = {64'd0, pp} << pp_amt;
        unique case (sh_reg)
            SH_16:   shamt = 6'd16;
            SH_30:   shamt = 6'd30;
            SH_32:   shamt = 6'd32;
            SH_48:   shamt = 6'd48;
            default: shamt = 6'd0;
        endcase
        shifted = $signed(acc_reg) >>> shamt;
        if ((shifted[127:63] == '0) || (shifted[127:63] == '1))
        begin
            sat_val = shifted[63:0];
        end
        else
        begin
            sat_val = shifted[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 3'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 3'd0;
            end
            else if (busy_reg)
            begin
                phase_reg <= phase_reg + 3'd1;
                if (phase_reg == 3'd5)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ua_reg  <= a[63] ? (~a + 64'd1) : a;
            ub_reg  <= b[63] ? (~b + 64'd1) : b;
            neg_reg <= a[63] ^ b[63];
            sh_reg  <= sh;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (phase_reg < 3'd4)
            begin
                acc_reg <= acc_reg + pp_sh;
            end
            else if (phase_reg == 3'd4)
            begin
                acc_reg <= neg_reg ? (~acc_reg + 128'd1) : acc_reg;
            end
            else
            begin
                result_reg <= sat_val;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// ===== sv/pdko_div.sv =====
// Radix-2 restoring divider for the Kalman gain: (num * 2^48) / den, toward zero, saturated.
// Depends on pdko_pkg only by convention; den is positive whenever started.
`default_nettype none
module pdko_div (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  wire  signed [63:0]  num,
    input  wire  signed [63:0]  den,
    output logic                done,
    output logic signed [63:0]  result
);
    import pdko_pkg::*;

    logic         busy_reg;
    logic         fin_reg;
    logic [6:0]   cnt_reg;
    logic [63:0]  rem_reg;
    logic [111:0] dvd_reg;
    logic [111:0] q_reg;
    logic [63:0]  den_reg;
    logic         neg_reg;
    logic         done_reg;
    logic signed [63:0] result_reg;

    logic [64:0]  cand;
    logic [65:0]  diff;
    logic         ge;
    logic signed [63:0] fin_val;

    always_comb
    begin
        cand = {rem_reg, dvd_reg[111]};
        diff = {1'b0, cand} - {2'b00, den_reg};
        ge   = !diff[65];
        if (q_reg[111:63] != '0)
        begin
            fin_val = neg_reg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        else
        begin
            fin_val = neg_reg ? (~q_reg[63:0] + 64'd1) : q_reg[63:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= 7'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd111)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {(num[63] ? (~num + 64'd1) : num), 48'd0};
            den_reg <= den;
            neg_reg <= num[63];
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[63:0] : cand[63:0];
            q_reg   <= {q_reg[110:0], ge};
            dvd_reg <= {dvd_reg[110:0], 1'b0};
        end
        else if (fin_reg)
        begin
            result_reg <= fin_val;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// ===== sv/pdko_datapath.sv =====
// Datapath: configuration registers, reading delay line, state register file, ALU,
// shared multiplier and divider, result register. Depends on pdko_pkg, pdko_mul, pdko_div.
`default_nettype none
module pdko_datapath #(
    parameter int DELAY = pdko_pkg::DELAY_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_we,
    input  wire  [3:0]         cfg_index,
    input  wire  [47:0]        cfg_data,
    input  wire  signed [31:0] reference_pos,
    input  wire  signed [31:0] encoder_pos,
    input  pdko_pkg::cmd_t     cmd,
    output pdko_pkg::stat_t    stat,
    output logic signed [31:0] drive,
    output logic signed [31:0] est_position,
    output logic signed [31:0] est_velocity,
    output logic signed [31:0] est_bias,
    output logic               corrected
);
    import pdko_pkg::*;

    localparam int LEN    = DELAY + 1;
    localparam int PTR_W  = (LEN > 1) ? $clog2(LEN) : 1;
    localparam int FILL_W = $clog2(LEN + 1);

    logic [30:0] prop_gain_reg;
    logic [30:0] deriv_gain_reg;
    logic [31:0] step_time_reg;
    logic [31:0] velocity_decay_reg;
    logic [31:0] drive_gain_reg;
    logic [47:0] noise_position_reg;
    logic [47:0] noise_velocity_reg;
    logic [47:0] noise_measure_reg;

    logic signed [31:0] ref_reg;
    logic [31:0]        line_mem [LEN];
    logic [31:0]        line_rd_reg;
    logic [PTR_W-1:0]   wptr_reg;
    logic [FILL_W-1:0]  fill_reg;

    logic signed [63:0] rf_mem [64];
    logic signed [63:0] rda_reg;
    logic signed [63:0] rdb_reg;
    logic [5:0]         addra_reg;
    logic [5:0]         addrb_reg;
    logic               va_reg;
    logic               vb_reg;
    logic [NUM_STATE-1:0] valid_reg;

    logic signed [63:0] res_reg;
    logic               nonpos_reg;
    logic [31:0]        drive_reg;
    logic [31:0]        est_hi_reg [3];
    logic               corr_reg;

    logic [31:0]        out_drive_reg;
    logic [31:0]        out_pos_reg;
    logic [31:0]        out_vel_reg;
    logic [31:0]        out_bias_reg;
    logic               out_corr_reg;

    logic signed [63:0] spec [16];
    logic signed [63:0] mema;
    logic signed [63:0] memb;
    logic signed [63:0] opa;
    logic signed [63:0] opb;
    logic [64:0]        sum65;
    logic [64:0]        dif65;
    logic signed [63:0] sum_sat;
    logic signed [63:0] dif_sat;
    logic signed [63:0] clamp_val;
    logic               mul_start;
    logic               div_start;
    logic               mul_done;
    logic               div_done;
    logic signed [63:0] mul_res;
    logic signed [63:0] div_res;
    uop_t               uop;

    assign uop = cmd.uop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg      <= 31'd3276800;
            deriv_gain_reg     <= 31'd207243;
            step_time_reg      <= 32'd4294967;
            velocity_decay_reg <= 32'd1073527076;
            drive_gain_reg     <= 32'd85899346;
            noise_position_reg <= 48'd281474977;
            noise_velocity_reg <= 48'd28147497671;
            noise_measure_reg  <= 48'd28147497671;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PROP_GAIN:      prop_gain_reg      <= cfg_data[30:0];
                CFG_DERIV_GAIN:     deriv_gain_reg     <= cfg_data[30:0];
                CFG_STEP_TIME:      step_time_reg      <= cfg_data[31:0];
                CFG_VELOCITY_DECAY: velocity_decay_reg <= cfg_data[31:0];
                CFG_DRIVE_GAIN:     drive_gain_reg     <= cfg_data[31:0];
                CFG_NOISE_POSITION: noise_position_reg <= cfg_data;
                CFG_NOISE_VELOCITY: noise_velocity_reg <= cfg_data;
                CFG_NOISE_MEASURE:  noise_measure_reg  <= cfg_data;
                default:            ;
            endcase
        end
    end

    // delay line
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            line_mem[wptr_reg] <= encoder_pos;
            ref_reg            <= reference_pos;
        end
        line_rd_reg <= line_mem[wptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            fill_reg <= '0;
        end
        else if (cmd.accept)
        begin
            wptr_reg <= (wptr_reg == PTR_W'(LEN - 1)) ? '0 : wptr_reg + PTR_W'(1);
            if (fill_reg != FILL_W'(LEN))
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
        end
    end

    // register file
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            rf_mem[uop.dst[5:0]] <= res_reg;
        end
        rda_reg   <= rf_mem[uop.a[5:0]];
        rdb_reg   <= rf_mem[uop.b[5:0]];
        addra_reg <= uop.a[5:0];
        addrb_reg <= uop.b[5:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
        end
        else
        begin
            va_reg <= (uop.a[5:0] >= 6'(NUM_STATE)) || valid_reg[uop.a[3:0]];
            vb_reg <= (uop.b[5:0] >= 6'(NUM_STATE)) || valid_reg[uop.b[3:0]];
            if (cmd.write && (uop.dst[5:0] < 6'(NUM_STATE)))
            begin
                valid_reg[uop.dst[3:0]] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        spec     = '{default: '0};
        spec[1]  = 64'sd1;
        spec[2]  = 64'sh1_0000_0000;
        spec[3]  = {{32{ref_reg[31]}}, ref_reg};
        spec[4]  = {{32{line_rd_reg[31]}}, line_rd_reg};
        spec[5]  = {33'd0, prop_gain_reg};
        spec[6]  = {33'd0, deriv_gain_reg};
        spec[7]  = {32'd0, step_time_reg};
        spec[8]  = {32'd0, velocity_decay_reg};
        spec[9]  = {32'd0, drive_gain_reg};
        spec[10] = {16'd0, noise_position_reg};
        spec[11] = {16'd0, noise_velocity_reg};
        spec[12] = $signed(NOISE_BIAS);
        spec[13] = {16'd0, noise_measure_reg};

        if (va_reg)
        begin
            mema = rda_reg;
        end
        else
        begin
            mema = ((addra_reg == R_P0[5:0]) || (addra_reg == R_P4[5:0]) ||
                    (addra_reg == R_P8[5:0])) ? COV_INIT : '0;
        end
        if (vb_reg)
        begin
            memb = rdb_reg;
        end
        else
        begin
            memb = ((addrb_reg == R_P0[5:0]) || (addrb_reg == R_P4[5:0]) ||
                    (addrb_reg == R_P8[5:0])) ? COV_INIT : '0;
        end
        opa = uop.a[6] ? spec[uop.a[3:0]] : mema;
        opb = uop.b[6] ? spec[uop.b[3:0]] : memb;

        sum65 = {opa[63], opa} + {opb[63], opb};
        dif65 = {opa[63], opa} - {opb[63], opb};
        if (sum65[64] != sum65[63])
        begin
            sum_sat = sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        else
        begin
            sum_sat = sum65[63:0];
        end
        if (dif65[64] != dif65[63])
        begin
            dif_sat = dif65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        else
        begin
            dif_sat = dif65[63:0];
        end
        if (opa > 64'sd2147483647)
        begin
            clamp_val = 64'sd2147483647;
        end
        else if (opa < -64'sd2147483648)
        begin
            clamp_val = -64'sd2147483648;
        end
        else
        begin
            clamp_val = opa;
        end
        mul_start = cmd.exec && (uop.op == OP_MUL);
        div_start = cmd.exec && (uop.op == OP_DIV);
    end

    pdko_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (opa),
        .b      (opb),
        .sh     (uop.sh),
        .done   (mul_done),
        .result (mul_res)
    );

    pdko_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (opa),
        .den    (opb),
        .done   (div_done),
        .result (div_res)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            unique case (uop.op)
                OP_ADD:   res_reg <= sum_sat;
                OP_SUB:   res_reg <= dif_sat;
                OP_CLAMP:
                begin
                    res_reg   <= clamp_val;
                    drive_reg <= clamp_val[31:0];
                end
                default:  ;
            endcase
        end
        else if (mul_done)
        begin
            res_reg <= mul_res;
        end
        else if (div_done)
        begin
            res_reg <= div_res;
        end
        if (cmd.load_out)
        begin
            out_drive_reg <= drive_reg;
            out_pos_reg   <= est_hi_reg[0];
            out_vel_reg   <= est_hi_reg[1];
            out_bias_reg  <= est_hi_reg[2];
            out_corr_reg  <= corr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonpos_reg <= 1'b0;
            corr_reg   <= 1'b0;
            est_hi_reg <= '{default: '0};
        end
        else
        begin
            if (cmd.accept)
            begin
                corr_reg <= 1'b0;
            end
            else if (cmd.set_corr)
            begin
                corr_reg <= 1'b1;
            end
            if (cmd.write)
            begin
                nonpos_reg <= res_reg[63] || (res_reg == '0);
                if (uop.dst[5:0] < 6'd3)
                begin
                    est_hi_reg[uop.dst[1:0]] <= res_reg[63:32];
                end
            end
        end
    end

    assign stat.full   = (fill_reg == FILL_W'(LEN));
    assign stat.nonpos = nonpos_reg;
    assign stat.done   = mul_done || div_done;

    assign drive        = out_drive_reg;
    assign est_position = out_pos_reg;
    assign est_velocity = out_vel_reg;
    assign est_bias     = out_bias_reg;
    assign corrected    = out_corr_reg;

endmodule
`default_nettype wire

// ===== sv/pdko_ctrl.sv =====
// Controller: steps the micro-program, issues datapath commands, holds the output valid.
// Depends on pdko_pkg.
`default_nettype none
module pdko_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire              m_tready,
    input  pdko_pkg::stat_t  stat,
    output pdko_pkg::cmd_t   cmd
);
    import pdko_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic [6:0] pc_reg;
    logic [6:0] pc_next;
    logic       out_valid_reg;
    uop_t       uop;

    assign uop = ucode(pc_reg);

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_FETCH;
                    pc_next    = 7'd0;
                end
            end
            ST_FETCH:
            begin
                unique case (uop.op)
                    OP_END:
                    begin
                        state_next = ST_FINISH;
                    end
                    OP_BR_FULL:
                    begin
                        if (!stat.full)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            pc_next = pc_reg + 7'd1;
                        end
                    end
                    OP_BR_POS:
                    begin
                        if (stat.nonpos)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            pc_next = pc_reg + 7'd1;
                        end
                    end
                    default:
                    begin
                        state_next = ST_EXEC;
                    end
                endcase
            end
            ST_EXEC:
            begin
                state_next = ((uop.op == OP_MUL) || (uop.op == OP_DIV)) ? ST_WAIT : ST_WRITE;
            end
            ST_WAIT:
            begin
                if (stat.done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_FETCH;
                pc_next    = pc_reg + 7'd1;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.uop      = uop;
        cmd.accept   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.exec     = (state_reg == ST_EXEC);
        cmd.write    = (state_reg == ST_WRITE);
        cmd.set_corr = (state_reg == ST_FETCH) && (uop.op == OP_BR_POS) && !stat.nonpos;
        cmd.load_out = (state_reg == ST_FINISH) && (!out_valid_reg || m_tready);
        s_tready     = (state_reg == ST_IDLE);
        m_tvalid     = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= 7'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("output overwritten while held");

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (pc_reg <= PC_END))
        else $error("program counter past end");

    a_done_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT && stat.done) |=> (state_reg == ST_WRITE))
        else $error("unit result not written");

    a_corr_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_corr |-> stat.full)
        else $error("update applied before delay line filled");
`endif

endmodule
`default_nettype wire

// ===== sv/pd_drive_with_delayed_kalman_observer_unit.sv =====
// An item ends after the state and covariance prediction while the delay line fills, after the
// innovation check when the innovation variance is not positive, and after the delayed update
// otherwise. A new item is accepted only once the last one has finished; the next item is
// accepted while a result waits, but it cannot finish until that result is taken. The run
// time is set by the serial multiplier and the three gain divisions.
// Reset: asynchronous, active low; estimate zero, covariance 0.01 on the diagonal,
// delay line empty, configuration at its defaults.
`default_nettype none
module pd_drive_with_delayed_kalman_observer_unit #(
    parameter int DELAY = pdko_pkg::DELAY_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [63:0]  s_tdata,   // reference_pos, encoder_pos
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [127:0] m_tdata,   // drive, est_position, est_velocity, est_bias
    output logic         m_tuser,   // corrected
    input  wire          cfg_we,
    input  wire  [3:0]   cfg_index,
    input  wire  [47:0]  cfg_data
);
    import pdko_pkg::*;

    cmd_t               cmd;
    stat_t              stat;
    logic signed [31:0] drive;
    logic signed [31:0] est_position;
    logic signed [31:0] est_velocity;
    logic signed [31:0] est_bias;
    logic               corrected;

    pdko_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pdko_datapath #(
        .DELAY (DELAY)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .reference_pos (s_tdata[31:0]),
        .encoder_pos   (s_tdata[63:32]),
        .cmd           (cmd),
        .stat          (stat),
        .drive         (drive),
        .est_position  (est_position),
        .est_velocity  (est_velocity),
        .est_bias      (est_bias),
        .corrected     (corrected)
    );

    assign m_tdata = {est_bias, est_velocity, est_position, drive};
    assign m_tuser = corrected;

endmodule
`default_nettype wire
